FILE: rtl/idll_pkg.sv
// Package for the indexed doubly linked list: widths, codes, node record and helpers.
`default_nettype none

package idll_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int VALUE_W    = 32;
    localparam int HANDLE_W   = $clog2(POOL_DEPTH + 1);
    localparam int SLOT_W     = $clog2(POOL_DEPTH);

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [VALUE_W-1:0]  value_t;

    // Operation codes
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_DELETE     = 3'd2;
    localparam logic [2:0] KIND_INS_BEFORE = 3'd3;
    localparam logic [2:0] KIND_INS_AFTER  = 3'd4;
    localparam logic [2:0] KIND_READ_NEXT  = 3'd5;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_BAD  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_END  = 2'd3;

    localparam handle_t NULL_HANDLE = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LINK
    } state_t;

    // Node record of the node memory; prev links live in a memory of their own
    typedef struct packed {
        logic    live;
        handle_t next;
        value_t  value;
    } node_t;

    // Field write enables of the node memory
    typedef struct packed {
        logic live;
        logic next;
        logic value;
    } node_we_t;

    // Pool slot of a valid handle (1..POOL_DEPTH)
    function automatic slot_t slot_of(handle_t h);
        handle_t d;
        d = h - handle_t'(1);
        return d[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/indexed_doubly_linked_list.sv
// Indexed doubly linked list over a fixed node pool held in two synchronous memories.
//
// Usage: drive kind, handle and value and raise start; the request is taken
// at the rising edge where start is high and busy is low. Exactly one result
// per request comes back on status, new_handle, read_value and last, marked
// by done for one cycle. The receiver cannot stall, so the result is simply
// presented once.
// Sequence: the request edge also issues the memory read; the next cycle
// evaluates and does the first write set. Read next, push onto an empty
// list, rejected requests and unused kinds then return to idle and raise
// done. Push onto a non-empty list, insert before/after and delete need a
// second write in the link state on the single write port of each memory.
// busy stays high until done, so a new request waits for the last result.
// Reset: head, tail, read cursor and walk flag go null, the issued count
// goes to zero. The memories are not cleared; only nodes of issued handles are used.
// Handles are never reused: the pool is full after POOL_DEPTH inserts.
`default_nettype none

module indexed_doubly_linked_list (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [2:0]                       kind,
    input  wire  [idll_pkg::HANDLE_W-1:0]    handle,
    input  wire  signed [idll_pkg::VALUE_W-1:0] value,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [idll_pkg::HANDLE_W-1:0]    new_handle,
    output logic signed [idll_pkg::VALUE_W-1:0] read_value,
    output logic                             last
);

    // Memories
    idll_pkg::node_t   node_mem [idll_pkg::POOL_DEPTH];
    idll_pkg::handle_t prev_mem [idll_pkg::POOL_DEPTH];

    idll_pkg::node_t   node_rd_reg;
    idll_pkg::handle_t prev_rd_reg;

    // Control state
    idll_pkg::state_t  state_reg, state_next;
    idll_pkg::handle_t head_reg, head_next;
    idll_pkg::handle_t tail_reg, tail_next;
    idll_pkg::handle_t issued_reg, issued_next;
    idll_pkg::handle_t cursor_reg, cursor_next;
    logic              walk_reg, walk_next;
    logic              done_reg, done_next;

    // Latched request
    logic [2:0]        kind_reg;
    idll_pkg::handle_t handle_reg;
    idll_pkg::value_t  value_reg;
    idll_pkg::handle_t cur_reg;
    logic              range_ok_reg;

    // Pending second write
    logic               p2_en_reg, p2_en_next;
    idll_pkg::slot_t    p2_slot_reg, p2_slot_next;
    idll_pkg::handle_t  p2_data_reg, p2_data_next;
    idll_pkg::node_we_t n2_we_reg, n2_we_next;
    idll_pkg::slot_t    n2_slot_reg, n2_slot_next;
    idll_pkg::node_t    n2_data_reg, n2_data_next;

    // Result registers
    logic [1:0]        status_reg, status_next;
    idll_pkg::handle_t nh_reg, nh_next;
    idll_pkg::value_t  rv_reg, rv_next;
    logic              last_reg, last_next;

    // Write ports
    logic               p_we;
    idll_pkg::slot_t    p_wa;
    idll_pkg::handle_t  p_wd;
    idll_pkg::node_we_t n_we;
    idll_pkg::slot_t    n_wa;
    idll_pkg::node_t    n_wd;

    logic              accept;
    idll_pkg::handle_t rd_handle;
    idll_pkg::slot_t   rd_slot;
    idll_pkg::handle_t new_h;
    idll_pkg::slot_t   new_slot;
    idll_pkg::slot_t   tgt_slot;
    logic              full;
    logic              bad;

    assign busy     = (state_reg != idll_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign new_h    = issued_reg + idll_pkg::handle_t'(1);
    assign new_slot = issued_reg[idll_pkg::SLOT_W-1:0];
    assign tgt_slot = idll_pkg::slot_of(handle_reg);
    assign full     = (issued_reg == idll_pkg::HANDLE_W'(idll_pkg::POOL_DEPTH));
    assign bad      = !range_ok_reg || !node_rd_reg.live;

    // Pick the read address: cursor or head for read next, target otherwise
    always_comb
    begin
        rd_handle = walk_reg ? cursor_reg : head_reg;
        if (kind == idll_pkg::KIND_READ_NEXT)
            rd_slot = idll_pkg::slot_of(rd_handle);
        else
            rd_slot = idll_pkg::slot_of(handle);
    end

    // Node memory: field-enabled write, registered read
    always_ff @(posedge clk)
    begin
        if (n_we.value)
            node_mem[n_wa].value <= n_wd.value;
        if (n_we.next)
            node_mem[n_wa].next <= n_wd.next;
        if (n_we.live)
            node_mem[n_wa].live <= n_wd.live;
        if (accept)
            node_rd_reg <= node_mem[rd_slot];
    end

    // Prev link memory: one write, registered read
    always_ff @(posedge clk)
    begin
        if (p_we)
            prev_mem[p_wa] <= p_wd;
        if (accept)
            prev_rd_reg <= prev_mem[rd_slot];
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind;
            handle_reg   <= handle;
            value_reg    <= value;
            cur_reg      <= rd_handle;
            range_ok_reg <= (handle != idll_pkg::NULL_HANDLE) && (handle <= issued_reg);
        end
    end

    // Hold pending writes and results
    always_ff @(posedge clk)
    begin
        p2_slot_reg <= p2_slot_next;
        p2_data_reg <= p2_data_next;
        n2_slot_reg <= n2_slot_next;
        n2_data_reg <= n2_data_next;
        status_reg  <= status_next;
        nh_reg      <= nh_next;
        rv_reg      <= rv_next;
        last_reg    <= last_next;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= idll_pkg::ST_IDLE;
            head_reg   <= idll_pkg::NULL_HANDLE;
            tail_reg   <= idll_pkg::NULL_HANDLE;
            issued_reg <= '0;
            cursor_reg <= idll_pkg::NULL_HANDLE;
            walk_reg   <= 1'b0;
            done_reg   <= 1'b0;
            p2_en_reg  <= 1'b0;
            n2_we_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            issued_reg <= issued_next;
            cursor_reg <= cursor_next;
            walk_reg   <= walk_next;
            done_reg   <= done_next;
            p2_en_reg  <= p2_en_next;
            n2_we_reg  <= n2_we_next;
        end
    end

    // Evaluate the request, drive the write ports, advance the state
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        issued_next  = issued_reg;
        cursor_next  = cursor_reg;
        walk_next    = walk_reg;
        done_next    = 1'b0;
        p2_en_next   = p2_en_reg;
        p2_slot_next = p2_slot_reg;
        p2_data_next = p2_data_reg;
        n2_we_next   = n2_we_reg;
        n2_slot_next = n2_slot_reg;
        n2_data_next = n2_data_reg;
        status_next  = status_reg;
        nh_next      = nh_reg;
        rv_next      = rv_reg;
        last_next    = last_reg;
        p_we         = 1'b0;
        p_wa         = new_slot;
        p_wd         = idll_pkg::NULL_HANDLE;
        n_we         = '0;
        n_wa         = new_slot;
        n_wd         = '{live: 1'b1, next: idll_pkg::NULL_HANDLE, value: value_reg};

        unique case (state_reg)
            idll_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = idll_pkg::ST_EVAL;
            end

            idll_pkg::ST_EVAL:
            begin
                status_next  = idll_pkg::STAT_OK;
                nh_next      = idll_pkg::NULL_HANDLE;
                rv_next      = '0;
                last_next    = 1'b0;
                p2_en_next   = 1'b0;
                n2_we_next   = '0;
                p2_slot_next = tgt_slot;
                p2_data_next = new_h;
                n2_slot_next = tgt_slot;
                n2_data_next = '{live: 1'b0, next: new_h, value: value_reg};

                unique case (kind_reg)
                    idll_pkg::KIND_PUSH_FRONT:
                    begin
                        if (full)
                            status_next = idll_pkg::STAT_FULL;
                        else
                        begin
                            n_we         = '{live: 1'b1, next: 1'b1, value: 1'b1};
                            n_wd.next    = head_reg;
                            p_we         = 1'b1;
                            p_wd         = idll_pkg::NULL_HANDLE;
                            issued_next  = new_h;
                            nh_next      = new_h;
                            head_next    = new_h;
                            if (head_reg != idll_pkg::NULL_HANDLE)
                            begin
                                p2_en_next   = 1'b1;
                                p2_slot_next = idll_pkg::slot_of(head_reg);
                            end
                            else
                                tail_next = new_h;
                        end
                    end

                    idll_pkg::KIND_PUSH_BACK:
                    begin
                        if (full)
                            status_next = idll_pkg::STAT_FULL;
                        else
                        begin
                            n_we         = '{live: 1'b1, next: 1'b1, value: 1'b1};
                            n_wd.next    = idll_pkg::NULL_HANDLE;
                            p_we         = 1'b1;
                            p_wd         = tail_reg;
                            issued_next  = new_h;
                            nh_next      = new_h;
                            tail_next    = new_h;
                            if (tail_reg != idll_pkg::NULL_HANDLE)
                            begin
                                n2_we_next.next = 1'b1;
                                n2_slot_next    = idll_pkg::slot_of(tail_reg);
                            end
                            else
                                head_next = new_h;
                        end
                    end

                    idll_pkg::KIND_DELETE:
                    begin
                        if (bad)
                            status_next = idll_pkg::STAT_BAD;
                        else
                        begin
                            // Unlink from the predecessor and successor now
                            if (prev_rd_reg != idll_pkg::NULL_HANDLE)
                            begin
                                n_we.next = 1'b1;
                                n_wa      = idll_pkg::slot_of(prev_rd_reg);
                                n_wd.next = node_rd_reg.next;
                            end
                            else
                                head_next = node_rd_reg.next;
                            if (node_rd_reg.next != idll_pkg::NULL_HANDLE)
                            begin
                                p_we = 1'b1;
                                p_wa = idll_pkg::slot_of(node_rd_reg.next);
                                p_wd = prev_rd_reg;
                            end
                            else
                                tail_next = prev_rd_reg;
                            // Drop the live flag in the link state
                            n2_we_next.live   = 1'b1;
                            n2_data_next.live = 1'b0;
                            if (walk_reg && (cursor_reg == handle_reg))
                                cursor_next = node_rd_reg.next;
                        end
                    end

                    idll_pkg::KIND_INS_BEFORE:
                    begin
                        if (bad)
                            status_next = idll_pkg::STAT_BAD;
                        else if (full)
                            status_next = idll_pkg::STAT_FULL;
                        else
                        begin
                            n_we        = '{live: 1'b1, next: 1'b1, value: 1'b1};
                            n_wd.next   = handle_reg;
                            p_we        = 1'b1;
                            p_wd        = prev_rd_reg;
                            issued_next = new_h;
                            nh_next     = new_h;
                            p2_en_next  = 1'b1;
                            if (prev_rd_reg != idll_pkg::NULL_HANDLE)
                            begin
                                n2_we_next.next = 1'b1;
                                n2_slot_next    = idll_pkg::slot_of(prev_rd_reg);
                            end
                            else
                                head_next = new_h;
                        end
                    end

                    idll_pkg::KIND_INS_AFTER:
                    begin
                        if (bad)
                            status_next = idll_pkg::STAT_BAD;
                        else if (full)
                            status_next = idll_pkg::STAT_FULL;
                        else
                        begin
                            n_we            = '{live: 1'b1, next: 1'b1, value: 1'b1};
                            n_wd.next       = node_rd_reg.next;
                            p_we            = 1'b1;
                            p_wd            = handle_reg;
                            issued_next     = new_h;
                            nh_next         = new_h;
                            n2_we_next.next = 1'b1;
                            if (node_rd_reg.next != idll_pkg::NULL_HANDLE)
                            begin
                                p2_en_next   = 1'b1;
                                p2_slot_next = idll_pkg::slot_of(node_rd_reg.next);
                            end
                            else
                                tail_next = new_h;
                        end
                    end

                    idll_pkg::KIND_READ_NEXT:
                    begin
                        if (cur_reg == idll_pkg::NULL_HANDLE)
                        begin
                            status_next = idll_pkg::STAT_END;
                            walk_next   = 1'b0;
                        end
                        else
                        begin
                            rv_next     = node_rd_reg.value;
                            last_next   = (node_rd_reg.next == idll_pkg::NULL_HANDLE);
                            cursor_next = node_rd_reg.next;
                            walk_next   = 1'b1;
                        end
                    end

                    default:
                    begin
                    end
                endcase

                if (p2_en_next || (n2_we_next != '0))
                    state_next = idll_pkg::ST_LINK;
                else
                begin
                    state_next = idll_pkg::ST_IDLE;
                    done_next  = 1'b1;
                end
            end

            idll_pkg::ST_LINK:
            begin
                // Issue the held second writes
                p_we       = p2_en_reg;
                p_wa       = p2_slot_reg;
                p_wd       = p2_data_reg;
                n_we       = n2_we_reg;
                n_wa       = n2_slot_reg;
                n_wd       = n2_data_reg;
                p2_en_next = 1'b0;
                n2_we_next = '0;
                done_next  = 1'b1;
                state_next = idll_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = idll_pkg::ST_IDLE;
            end
        endcase
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign new_handle = nh_reg;
    assign read_value = rv_reg;
    assign last       = last_reg;

    // Checks
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == idll_pkg::ST_EVAL) ||
                     ($past(state_reg) == idll_pkg::ST_LINK))
        else $error("result strobe without a request in work");

    a_issued_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issued_reg <= idll_pkg::HANDLE_W'(idll_pkg::POOL_DEPTH))
        else $error("issued count beyond pool depth");

    a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == idll_pkg::ST_EVAL))
        else $error("request not evaluated in the next cycle");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != idll_pkg::STAT_OK)) |->
            (nh_reg == idll_pkg::NULL_HANDLE) && (rv_reg == '0) && !last_reg)
        else $error("rejected request returned data");

    a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == idll_pkg::NULL_HANDLE) == (tail_reg == idll_pkg::NULL_HANDLE))
        else $error("head and tail disagree on empty list");

endmodule

`default_nettype wire

FILE: tb/tb_indexed_doubly_linked_list.sv
// Testbench for the indexed doubly linked list: request streams checked against a list model.

module tb_indexed_doubly_linked_list;
    import idll_pkg::*;

    // Kinds that the block ignores
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    // Cycles without any request or result before the run is declared hung
    localparam int IDLE_LIMIT  = 4000;
    // Cycles to keep watching after the last result
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [1:0] status;
        handle_t    new_handle;
        value_t     read_value;
        logic       last;
    } list_reply_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [2:0] kind  = '0;
    handle_t    handle = '0;
    value_t     value  = '0;
    logic       busy;
    logic       done;
    logic [1:0] status;
    handle_t    new_handle;
    value_t     read_value;
    logic       last;

    indexed_doubly_linked_list dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .handle     (handle),
        .value      (value),
        .done       (done),
        .status     (status),
        .new_handle (new_handle),
        .read_value (read_value),
        .last       (last)
    );

    always #2 clk = ~clk;

    // List model state, indexed directly by handle
    value_t      pool_value [1:POOL_DEPTH];
    handle_t     pool_prev  [1:POOL_DEPTH];
    handle_t     pool_next  [1:POOL_DEPTH];
    bit          pool_live  [1:POOL_DEPTH];
    handle_t     head_h   = NULL_HANDLE;
    handle_t     tail_h   = NULL_HANDLE;
    handle_t     cursor_h = NULL_HANDLE;
    int          issued   = 0;
    bit          walking  = 1'b0;
    handle_t     live_handles[$];
    handle_t     dead_handles[$];

    list_reply_t expected_replies[$];
    int          errors    = 0;
    int          calm_left = 0;

    // Accept only issued handles whose node is still in the list
    function automatic bit handle_live(handle_t h);
        if (h == NULL_HANDLE || int'(h) > issued)
            return 1'b0;
        return pool_live[h];
    endfunction

    // Take the next handle and fill its node
    function automatic handle_t take_node(value_t v, handle_t p, handle_t n);
        handle_t h;
        issued++;
        h = handle_t'(issued);
        pool_value[h] = v;
        pool_prev[h]  = p;
        pool_next[h]  = n;
        pool_live[h]  = 1'b1;
        live_handles  = {live_handles, h};
        return h;
    endfunction

    // Apply one request to the list model and return the reply it must give
    function automatic list_reply_t predict_list_op(logic [2:0] op, handle_t h, value_t v);
        list_reply_t r;
        handle_t     p;
        handle_t     n;
        int          idx;
        r = '0;
        case (op)
            KIND_DELETE:
            begin
                if (!handle_live(h))
                begin
                    r.status = STAT_BAD;
                end
                else
                begin
                    p = pool_prev[h];
                    n = pool_next[h];
                    if (p != NULL_HANDLE) pool_next[p] = n; else head_h = n;
                    if (n != NULL_HANDLE) pool_prev[n] = p; else tail_h = p;
                    pool_live[h] = 1'b0;
                    idx = -1;
                    for (int i = 0; i < live_handles.size(); i++)
                        if (live_handles[i] == h) idx = i;
                    if (idx >= 0) live_handles.delete(idx);
                    dead_handles = {dead_handles, h};
                    // move the cursor off a deleted node
                    if (walking && cursor_h == h) cursor_h = n;
                end
            end
            KIND_READ_NEXT:
            begin
                if (!walking)
                begin
                    cursor_h = head_h;
                    walking  = 1'b1;
                end
                if (cursor_h == NULL_HANDLE)
                begin
                    r.status = STAT_END;
                    walking  = 1'b0;
                end
                else
                begin
                    r.read_value = pool_value[cursor_h];
                    r.last       = (pool_next[cursor_h] == NULL_HANDLE);
                    cursor_h     = pool_next[cursor_h];
                end
            end
            KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INS_BEFORE, KIND_INS_AFTER:
            begin
                if ((op == KIND_INS_BEFORE || op == KIND_INS_AFTER) && !handle_live(h))
                begin
                    r.status = STAT_BAD;
                end
                else if (issued >= POOL_DEPTH)
                begin
                    r.status = STAT_FULL;
                end
                else if (op == KIND_PUSH_FRONT)
                begin
                    n = take_node(v, NULL_HANDLE, head_h);
                    if (head_h != NULL_HANDLE) pool_prev[head_h] = n; else tail_h = n;
                    head_h = n;
                    r.new_handle = n;
                end
                else if (op == KIND_PUSH_BACK)
                begin
                    n = take_node(v, tail_h, NULL_HANDLE);
                    if (tail_h != NULL_HANDLE) pool_next[tail_h] = n; else head_h = n;
                    tail_h = n;
                    r.new_handle = n;
                end
                else if (op == KIND_INS_BEFORE)
                begin
                    p = pool_prev[h];
                    n = take_node(v, p, h);
                    pool_prev[h] = n;
                    if (p != NULL_HANDLE) pool_next[p] = n; else head_h = n;
                    r.new_handle = n;
                end
                else
                begin
                    p = pool_next[h];
                    n = take_node(v, h, p);
                    pool_next[h] = n;
                    if (p != NULL_HANDLE) pool_prev[p] = n; else tail_h = n;
                    r.new_handle = n;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic handle_t any_live_handle();
        if (live_handles.size() == 0)
            return NULL_HANDLE;
        return live_handles[$urandom_range(0, live_handles.size() - 1)];
    endfunction

    // Pick a handle that must be rejected: null, deleted or not yet issued
    function automatic handle_t stale_handle();
        case ($urandom_range(0, 2))
            0: return NULL_HANDLE;
            1: if (dead_handles.size() != 0)
                   return dead_handles[$urandom_range(0, dead_handles.size() - 1)];
            default: if (issued < POOL_DEPTH)
                   return handle_t'($urandom_range(issued + 1, POOL_DEPTH));
        endcase
        return NULL_HANDLE;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Idle a random number of cycles, then send one request and record its reply
    task automatic issue_request(input logic [2:0] op, input handle_t target, input value_t data);
        int n;
        int pick;
        n = 0;
        if (calm_left > 0)
        begin
            calm_left--;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                calm_left = $urandom_range(10, 40);
            else if (pick < 55)
                n = 0;
            else if (pick < 90)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(4, 30);
        end
        repeat (n) @(negedge clk) start <= 1'b0;
        @(negedge clk);
        kind   <= op;
        handle <= target;
        value  <= data;
        start  <= 1'b1;
        // hold the request until the block takes it
        do @(posedge clk); while (busy);
        expected_replies = {expected_replies, predict_list_op(op, target, data)};
    endtask

    // Drop start and hold off until every reply has come back
    task automatic wait_for_replies();
        @(negedge clk) start <= 1'b0;
        while (expected_replies.size() != 0) @(negedge clk);
    endtask

    // Empty list, bad handles, every insert position, unused kinds and cursor moves
    task automatic test_directed();
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_READ_NEXT, handle_t'(POOL_DEPTH), '1);
        issue_request(KIND_DELETE, NULL_HANDLE, '0);
        issue_request(KIND_DELETE, handle_t'(1), '0);
        issue_request(KIND_INS_BEFORE, handle_t'(5), 32'h0000_0001);
        issue_request(KIND_INS_AFTER, NULL_HANDLE, 32'h0000_0002);
        issue_request(KIND_PUSH_BACK, NULL_HANDLE, 32'h7FFF_FFFF);
        issue_request(KIND_PUSH_FRONT, handle_t'(POOL_DEPTH), 32'h8000_0000);
        issue_request(KIND_INS_AFTER, handle_t'(2), '1);
        issue_request(KIND_INS_BEFORE, handle_t'(2), '0);
        issue_request(KIND_INS_BEFORE, handle_t'(1), 32'h5555_AAAA);
        issue_request(KIND_INS_AFTER, handle_t'(1), 32'hA5A5_A5A5);
        issue_request(KIND_SPARE_6, handle_t'(POOL_DEPTH), '1);
        issue_request(KIND_SPARE_7, handle_t'(3), 32'h1234_5678);
        // walk 4 2 3 5 1 6, deleting nodes under and around the cursor
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_DELETE, handle_t'(3), '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_DELETE, handle_t'(3), '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_DELETE, handle_t'(6), '0);
        issue_request(KIND_DELETE, handle_t'(4), '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
        // delete the tail under the cursor, then read past the end
        issue_request(KIND_DELETE, handle_t'(1), '0);
        issue_request(KIND_READ_NEXT, NULL_HANDLE, '0);
    endtask

    // Mostly well-formed requests on live handles, some noise
    task automatic test_random_ops(input int count);
        int      pick;
        handle_t target;
        value_t  data;
        handle_t junk;
        for (int i = 0; i < count; i++)
        begin
            pick   = $urandom_range(0, 99);
            target = any_live_handle();
            data   = value_t'($urandom());
            junk   = handle_t'($urandom_range(0, POOL_DEPTH));
            if (i % 200 == 100)
                wait_for_replies();
            if (pick < 12)
                issue_request(KIND_PUSH_FRONT, junk, data);
            else if (pick < 24)
                issue_request(KIND_PUSH_BACK, junk, data);
            else if (pick < 34)
                issue_request(KIND_INS_BEFORE, target, data);
            else if (pick < 44)
                issue_request(KIND_INS_AFTER, target, data);
            else if (pick < 70)
                issue_request(KIND_DELETE, target, data);
            else if (pick < 73)
                issue_request(KIND_DELETE, (walking && cursor_h != NULL_HANDLE) ?
                              cursor_h : target, data);
            else if (pick < 93)
                issue_request(KIND_READ_NEXT, junk, data);
            else
            begin
                case ($urandom_range(0, 3))
                    0: issue_request(KIND_DELETE, stale_handle(), data);
                    1: issue_request($urandom_range(0, 1) ? KIND_INS_BEFORE : KIND_INS_AFTER,
                                     stale_handle(), data);
                    2: issue_request($urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7,
                                     junk, data);
                    default: issue_request(3'($urandom_range(0, 7)), junk, data);
                endcase
            end
        end
    endtask

    // Compare each result with the oldest recorded reply
    always @(posedge clk)
    begin : check_replies
        list_reply_t want;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual status %0d handle %0d",
                         $time, status, new_handle);
                errors++;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("new_handle", 32'(want.new_handle), 32'(new_handle));
                check_field("read_value", want.read_value, read_value);
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // End a hung run
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_indexed_doubly_linked_list NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_ops(722);
        wait_for_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_replies.size() == 0)
            $display("tb_indexed_doubly_linked_list OK");
        else
            $display("tb_indexed_doubly_linked_list NOT OK");
        $finish;
    end

endmodule
